// ----- hdl/ilir_pkg.sv -----
// Shared constants, codes and types of the indexed list insert/remove unit.
`default_nettype none

package ilir_pkg;

    localparam int CAPACITY = 16;
    localparam int POS_W    = 5;
    localparam int WORD_W   = 32;
    localparam int STAT_W   = 2;
    localparam int LEN_W    = 5;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_GET    = 2'd2,
        CMD_REMOVE = 2'd3
    } cmd_t;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic load;
    } dp_ctrl_t;

endpackage

`default_nettype wire

// ----- hdl/ilir_ctrl.sv -----
// Controller of the indexed list unit: input acceptance and output register state.
`default_nettype none

module ilir_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output ilir_pkg::dp_ctrl_t   ctrl
);
    import ilir_pkg::*;

    typedef enum logic {
        S_EMPTY,
        S_HOLD
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        in_stall   = (state_reg == S_HOLD) && out_stall;
        ctrl.load  = in_valid && !in_stall;
        out_valid  = (state_reg == S_HOLD);
        state_next = state_reg;
        case (state_reg)
            S_EMPTY:
            begin
                if (ctrl.load)
                    state_next = S_HOLD;
            end
            S_HOLD:
            begin
                if (!out_stall && !ctrl.load)
                    state_next = S_EMPTY;
            end
            default: state_next = S_EMPTY;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_EMPTY;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// ----- hdl/ilir_datapath.sv -----
// Datapath of the indexed list unit: entry cells, count, checks and result register.
`default_nettype none

module ilir_datapath (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire ilir_pkg::dp_ctrl_t              ctrl,
    input  wire logic [1:0]                      command,
    input  wire logic [ilir_pkg::POS_W-1:0]      position,
    input  wire logic [ilir_pkg::WORD_W-1:0]     value_in,
    output logic      [ilir_pkg::WORD_W-1:0]     value_out,
    output logic      [ilir_pkg::STAT_W-1:0]     status,
    output logic      [ilir_pkg::LEN_W-1:0]      length_out
);
    import ilir_pkg::*;

    logic [WORD_W-1:0] entries_reg  [CAPACITY];
    logic [WORD_W-1:0] entries_next [CAPACITY];
    logic [WORD_W-1:0] below        [CAPACITY];
    logic [WORD_W-1:0] above        [CAPACITY];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [WORD_W-1:0] value_reg;
    logic [WORD_W-1:0] value_next;
    logic [STAT_W-1:0] status_reg;
    logic [STAT_W-1:0] status_next;
    logic [LEN_W-1:0]  length_reg;
    logic [LEN_W-1:0]  length_next;

    cmd_t              cmd;
    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  cnt_ext;
    logic [CMP_W-1:0]  put_pos;
    logic [CMP_W-1:0]  cnt_next_ext;
    logic              is_full;
    logic              do_put;
    logic              do_take;
    logic [WORD_W-1:0] read_word;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_nbr
            if (g == 0)
            begin : g_first
                assign below[g] = '0;
            end
            else
            begin : g_below
                assign below[g] = entries_reg[g-1];
            end
            if (g == CAPACITY - 1)
            begin : g_last
                assign above[g] = '0;
            end
            else
            begin : g_above
                assign above[g] = entries_reg[g+1];
            end
        end
    endgenerate

    always_comb
    begin
        cmd       = cmd_t'(command);
        pos_ext   = CMP_W'(position);
        cnt_ext   = CMP_W'(count_reg);
        is_full   = (cnt_ext == CMP_W'(CAPACITY));
        put_pos   = (cmd == CMD_APPEND) ? cnt_ext : pos_ext;
        read_word = entries_reg[pos_ext[IDX_W-1:0]];

        status_next = ST_OK;
        case (cmd)
            CMD_APPEND:
            begin
                if (is_full)
                    status_next = ST_FULL;
            end
            CMD_INSERT:
            begin
                if (pos_ext > cnt_ext)
                    status_next = ST_RANGE;
                else if (is_full)
                    status_next = ST_FULL;
            end
            CMD_GET, CMD_REMOVE:
            begin
                if (pos_ext >= cnt_ext)
                    status_next = ST_RANGE;
            end
            default: status_next = ST_RANGE;
        endcase

        do_put  = ctrl.load && (status_next == ST_OK) &&
                  (cmd == CMD_APPEND || cmd == CMD_INSERT);
        do_take = ctrl.load && (status_next == ST_OK) && (cmd == CMD_REMOVE);

        count_next = count_reg;
        if (do_put)
            count_next = count_reg + CNT_W'(1);
        else if (do_take)
            count_next = count_reg - CNT_W'(1);

        for (int k = 0; k < CAPACITY; k++)
        begin
            entries_next[k] = entries_reg[k];
            if (do_put)
            begin
                if (CMP_W'(k) == put_pos)
                    entries_next[k] = value_in;
                else if (CMP_W'(k) > put_pos && CMP_W'(k) <= cnt_ext)
                    entries_next[k] = below[k];
            end
            else if (do_take)
            begin
                if (CMP_W'(k) >= pos_ext && CMP_W'(k) + CMP_W'(1) < cnt_ext)
                    entries_next[k] = above[k];
            end
        end

        value_next = '0;
        if (status_next == ST_OK && (cmd == CMD_GET || cmd == CMD_REMOVE))
            value_next = read_word;

        cnt_next_ext = CMP_W'(count_next);
        length_next  = cnt_next_ext[LEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            for (int k = 0; k < CAPACITY; k++)
                entries_reg[k] <= entries_next[k];
            value_reg  <= value_next;
            status_reg <= status_next;
            length_reg <= length_next;
        end
    end

    assign value_out  = value_reg;
    assign status     = status_reg;
    assign length_out = length_reg;

endmodule

`default_nettype wire

// ----- hdl/indexed_list_insert_remove_unit.sv -----
// Top level of the indexed list unit: append, insert, get and remove by index.
//
//   channel | handshake          | payload
//   --------+--------------------+------------------------------------
//   input   | in_valid, in_stall | command, position, value_in
//   output  | out_valid,out_stall| value_out, status, length_out
//
// One transaction per cycle: every command completes in the cycle it is
// accepted, shifting the entry cells in place, and its result appears in
// the output register on the next cycle. The input stalls only while a held
// result is stalled. Reset clears the count and the output valid; entry
// cells are not cleared, as only entries below the count are ever read.
`default_nettype none

module indexed_list_insert_remove_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [1:0]                      command,
    input  wire logic [ilir_pkg::POS_W-1:0]      position,
    input  wire logic [ilir_pkg::WORD_W-1:0]     value_in,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic      [ilir_pkg::WORD_W-1:0]     value_out,
    output logic      [ilir_pkg::STAT_W-1:0]     status,
    output logic      [ilir_pkg::LEN_W-1:0]      length_out
);
    import ilir_pkg::*;

    dp_ctrl_t ctrl;

    ilir_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ctrl      (ctrl)
    );

    ilir_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .command    (command),
        .position   (position),
        .value_in   (value_in),
        .value_out  (value_out),
        .status     (status),
        .length_out (length_out)
    );

endmodule

`default_nettype wire

// ----- hdl/ilir_checker.sv -----
// Port-level checker of the indexed list unit and its bind to the top level.
`default_nettype none

module ilir_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    input  wire logic                            in_stall,
    input  wire logic                            out_valid,
    input  wire logic                            out_stall,
    input  wire logic [ilir_pkg::WORD_W-1:0]     value_out,
    input  wire logic [ilir_pkg::STAT_W-1:0]     status,
    input  wire logic [ilir_pkg::LEN_W-1:0]      length_out
);
    import ilir_pkg::*;

    localparam int CAP_CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    localparam logic [CAP_CMP_W-1:0] CAP_EXT = CAP_CMP_W'(CAPACITY);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output transaction dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(value_out) && $stable(status) &&
                                   $stable(length_out))
        else $error("stalled output payload changed");

    a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted transaction gave no result");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> value_out == '0)
        else $error("failed command returned a nonzero value");

    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> length_out == CAP_EXT[LEN_W-1:0])
        else $error("full status with a length below capacity");

endmodule

bind indexed_list_insert_remove_unit ilir_checker u_ilir_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .value_out  (value_out),
    .status     (status),
    .length_out (length_out)
);

`default_nettype wire

// ----- sim/tb_indexed_list_insert_remove_unit.sv -----
// Self-checking testbench of the indexed list insert/remove unit: directed table, then random traffic.
`default_nettype none

module tb_indexed_list_insert_remove_unit;

    import ilir_pkg::*;

    localparam int DIR_ROWS     = 20;
    localparam int RANDOM_ITEMS = 520;
    localparam int HOLD_AT_ITEM = 250;
    localparam int HOLD_CYCLES  = 60;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [STAT_W-1:0] stat;
        logic [LEN_W-1:0]  len;
    } list_result_t;

    typedef struct packed {
        cmd_t              op;
        logic [POS_W-1:0]  pos;
        logic [WORD_W-1:0] word;
        logic [4:0]        reps;
        logic              has_result;
        list_result_t      res;
    } list_stim_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [1:0]          command;
    logic [POS_W-1:0]    position;
    logic [WORD_W-1:0]   value_in;
    logic                out_valid;
    logic                out_stall;
    logic [WORD_W-1:0]   value_out;
    logic [STAT_W-1:0]   status;
    logic [LEN_W-1:0]    length_out;

    logic [WORD_W-1:0]   list_words [CAPACITY];
    int                  list_len;
    list_result_t        pending_results [$];

    int                  cycle_count;
    int                  mismatch_count;
    int                  sent_count;
    int                  ok_count;
    int                  range_count;
    int                  full_count;
    int                  peak_len;
    int                  input_stall_cycles;
    bit                  hold_armed;

    list_stim_t directed_rows [DIR_ROWS] = '{
        '{CMD_GET,    5'd0,  32'h0000_0000, 5'd1,  1'b1, '{32'h0000_0000, ST_RANGE, 5'd0}},
        '{CMD_REMOVE, 5'd0,  32'h0000_0000, 5'd1,  1'b1, '{32'h0000_0000, ST_RANGE, 5'd0}},
        '{CMD_INSERT, 5'd1,  32'hDEAD_BEEF, 5'd1,  1'b1, '{32'h0000_0000, ST_RANGE, 5'd0}},
        '{CMD_GET,    5'd31, 32'h0000_0000, 5'd1,  1'b1, '{32'h0000_0000, ST_RANGE, 5'd0}},
        '{CMD_INSERT, 5'd0,  32'hFFFF_FFFF, 5'd1,  1'b1, '{32'h0000_0000, ST_OK,    5'd1}},
        '{CMD_INSERT, 5'd0,  32'h0000_0000, 5'd1,  1'b1, '{32'h0000_0000, ST_OK,    5'd2}},
        '{CMD_GET,    5'd1,  32'h0000_0000, 5'd1,  1'b1, '{32'hFFFF_FFFF, ST_OK,    5'd2}},
        '{CMD_INSERT, 5'd1,  32'hAAAA_AAAA, 5'd1,  1'b0, '{32'h0000_0000, ST_OK,    5'd0}},
        '{CMD_APPEND, 5'd0,  32'h5555_5550, 5'd13, 1'b0, '{32'h0000_0000, ST_OK,    5'd0}},
        '{CMD_APPEND, 5'd9,  32'h1234_5678, 5'd1,  1'b1, '{32'h0000_0000, ST_FULL,  5'd16}},
        '{CMD_INSERT, 5'd16, 32'h8765_4321, 5'd1,  1'b1, '{32'h0000_0000, ST_FULL,  5'd16}},
        '{CMD_INSERT, 5'd17, 32'h8765_4321, 5'd1,  1'b1, '{32'h0000_0000, ST_RANGE, 5'd16}},
        '{CMD_INSERT, 5'd0,  32'h0F0F_0F0F, 5'd1,  1'b1, '{32'h0000_0000, ST_FULL,  5'd16}},
        '{CMD_GET,    5'd16, 32'h0000_0000, 5'd1,  1'b1, '{32'h0000_0000, ST_RANGE, 5'd16}},
        '{CMD_GET,    5'd15, 32'h0000_0000, 5'd1,  1'b0, '{32'h0000_0000, ST_OK,    5'd0}},
        '{CMD_REMOVE, 5'd16, 32'h0000_0000, 5'd1,  1'b1, '{32'h0000_0000, ST_RANGE, 5'd16}},
        '{CMD_REMOVE, 5'd0,  32'h0000_0000, 5'd1,  1'b1, '{32'h0000_0000, ST_OK,    5'd15}},
        '{CMD_REMOVE, 5'd14, 32'h0000_0000, 5'd1,  1'b0, '{32'h0000_0000, ST_OK,    5'd0}},
        '{CMD_INSERT, 5'd14, 32'hC3C3_3C3C, 5'd1,  1'b0, '{32'h0000_0000, ST_OK,    5'd0}},
        '{CMD_REMOVE, 5'd1,  32'h0000_0000, 5'd1,  1'b1, '{32'hFFFF_FFFF, ST_OK,    5'd14}}
    };

    indexed_list_insert_remove_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .position   (position),
        .value_in   (value_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .value_out  (value_out),
        .status     (status),
        .length_out (length_out)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    function automatic list_result_t apply_list_cmd(input cmd_t op, input logic [POS_W-1:0] pos,
                                                    input logic [WORD_W-1:0] word);
        list_result_t r;
        int k;
        r      = '0;
        r.stat = ST_OK;
        case (op)
            CMD_APPEND:
            begin
                if (list_len >= CAPACITY)
                    r.stat = ST_FULL;
                else
                begin
                    list_words[list_len] = word;
                    list_len++;
                end
            end
            CMD_INSERT:
            begin
                if (int'(pos) > list_len)
                    r.stat = ST_RANGE;
                else if (list_len >= CAPACITY)
                    r.stat = ST_FULL;
                else
                begin
                    for (k = list_len; k > int'(pos); k--)
                        list_words[k] = list_words[k-1];
                    list_words[pos] = word;
                    list_len++;
                end
            end
            CMD_GET:
            begin
                if (int'(pos) >= list_len)
                    r.stat = ST_RANGE;
                else
                    r.word = list_words[pos];
            end
            default:
            begin
                if (int'(pos) >= list_len)
                    r.stat = ST_RANGE;
                else
                begin
                    r.word = list_words[pos];
                    for (k = int'(pos); k + 1 < list_len; k++)
                        list_words[k] = list_words[k+1];
                    list_len--;
                end
            end
        endcase
        r.len = list_len[LEN_W-1:0];
        return r;
    endfunction

    task automatic send_cmd(input cmd_t op, input logic [POS_W-1:0] pos,
                            input logic [WORD_W-1:0] word, input logic has_result,
                            input list_result_t res);
        list_result_t predicted;
        in_valid <= 1'b1;
        command  <= op;
        position <= pos;
        value_in <= word;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = apply_list_cmd(op, pos, word);
        pending_results.push_back(has_result ? res : predicted);
        sent_count++;
        if (list_len > peak_len)
            peak_len = list_len;
    endtask

    // receiver: random stall pattern, re-chosen among four modes, plus one long hold
    initial
    begin
        int mode;
        int mode_cycles;
        int hold_left;
        bit hold_done;
        mode        = 0;
        mode_cycles = 0;
        hold_left   = 0;
        hold_done   = 1'b0;
        out_stall   = 1'b0;
        forever
        begin
            @(posedge clk);
            mode_cycles++;
            if (mode_cycles == 48)
            begin
                mode_cycles = 0;
                mode        = $urandom_range(0, 3);
            end
            if (hold_armed && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 1) == 1);
                    2: out_stall <= ($urandom_range(0, 99) < 15);
                    default: out_stall <= (mode_cycles % 4 == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        list_result_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
        else
        begin
            if (in_valid && in_stall)
                input_stall_cycles++;
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected transaction value_out %h status %0d length_out %0d",
                             $time, value_out, status, length_out);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (value_out !== want.word)
                    begin
                        $display("%0t: value_out expected %h actual %h",
                                 $time, want.word, value_out);
                        mismatch_count++;
                    end
                    if (status !== want.stat)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.stat, status);
                        mismatch_count++;
                    end
                    if (length_out !== want.len)
                    begin
                        $display("%0t: length_out expected %0d actual %0d",
                                 $time, want.len, length_out);
                        mismatch_count++;
                    end
                    case (want.stat)
                        ST_OK:    ok_count++;
                        ST_RANGE: range_count++;
                        default:  full_count++;
                    endcase
                end
            end
        end
    end

    initial
    begin
        int row;
        int rep;
        int n;
        int r;
        int burst_left;
        int gap;
        bit grow_phase;
        cmd_t op;
        logic [POS_W-1:0] pos;
        logic [WORD_W-1:0] word;
        rst_n              = 1'b0;
        in_valid           = 1'b0;
        command            = CMD_APPEND;
        position           = '0;
        value_in           = '0;
        hold_armed         = 1'b0;
        cycle_count        = 0;
        mismatch_count     = 0;
        sent_count         = 0;
        ok_count           = 0;
        range_count        = 0;
        full_count         = 0;
        peak_len           = 0;
        input_stall_cycles = 0;
        list_len           = 0;
        for (row = 0; row < CAPACITY; row++)
            list_words[row] = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row = 0; row < DIR_ROWS; row++)
            for (rep = 0; rep < int'(directed_rows[row].reps); rep++)
                send_cmd(directed_rows[row].op, directed_rows[row].pos,
                         directed_rows[row].word + WORD_W'(rep),
                         directed_rows[row].has_result, directed_rows[row].res);

        burst_left = $urandom_range(1, 24);
        grow_phase = 1'b0;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 40 == 0)
                grow_phase = ~grow_phase;
            if (n == HOLD_AT_ITEM)
                hold_armed = 1'b1;
            r = $urandom_range(0, 99);
            if (grow_phase)
                op = (r < 45) ? CMD_APPEND : (r < 70) ? CMD_INSERT : (r < 85) ? CMD_GET : CMD_REMOVE;
            else
                op = (r < 10) ? CMD_APPEND : (r < 20) ? CMD_INSERT : (r < 45) ? CMD_GET : CMD_REMOVE;
            if ($urandom_range(0, 9) == 0)
                pos = POS_W'($urandom_range(0, 31));
            else if (op == CMD_INSERT)
                pos = POS_W'($urandom_range(0, list_len));
            else if (list_len > 0)
                pos = POS_W'($urandom_range(0, list_len - 1));
            else
                pos = '0;
            case ($urandom_range(0, 7))
                0: word = '0;
                1: word = '1;
                default: word = $urandom;
            endcase
            send_cmd(op, pos, word, 1'b0, '0);
            burst_left--;
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap        = $urandom_range(0, 5);
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("Ran %0d commands: %0d ok, %0d index out of range, %0d list full",
                 sent_count, ok_count, range_count, full_count);
        $display("Peak length %0d of %0d, input stalled for %0d cycles",
                 peak_len, CAPACITY, input_stall_cycles);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
hdl/ilir_pkg.sv
hdl/ilir_ctrl.sv
hdl/ilir_datapath.sv
hdl/indexed_list_insert_remove_unit.sv
hdl/ilir_checker.sv
sim/tb_indexed_list_insert_remove_unit.sv
